>>> design/matrix_vector_multiply_top_defines.svh
// Assertion macros for the matrix-vector multiply block.
`ifndef MATRIX_VECTOR_MULTIPLY_TOP_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_TOP_DEFINES_SVH
// Check that a condition implies a consequence on the same edge.
`define MVM_ASSERT_IMPLY(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);
// Check that a condition implies a consequence on the next edge.
`define MVM_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);
`endif

>>> design/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types, constants and single-precision helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mvm_pkg;

   localparam int unsigned FP_W = 32;
   localparam int unsigned SIZE_W = 3;
   localparam int unsigned NUM_REGS = 8;
   localparam int unsigned REG_W = 64;
   localparam int unsigned ADDR_W = 6;
   localparam logic [FP_W-1:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [FP_W-1:0] POS_ZERO = 32'h0000_0000;
   localparam logic [REG_W-1:0] RESET_ROW_A = 64'd1065353216;
   localparam logic [REG_W-1:0] RESET_ROW_B = 64'd4575657221408423936;
   localparam logic [REG_W-1:0] RESET_ZERO = 64'd0;

   typedef logic [FP_W-1:0] fp_type;

   typedef struct packed {
      fp_type comp_x;
      fp_type comp_y;
      fp_type comp_z;
      fp_type comp_w;
      logic [SIZE_W-1:0] vec_size;
   } req_type;

   typedef struct packed {
      fp_type res_x;
      fp_type res_y;
      fp_type res_z;
      fp_type res_w;
   } rsp_type;

   // Unpacked operand: special classes plus sign, exponent and significand.
   typedef struct packed {
      logic        nan;
      logic        inf;
      logic        zero;
      logic        sign;
      logic signed [9:0] exp;
      logic [23:0] man;
   } unp_type;

   function automatic unp_type fp_unpack(input fp_type a);
      unp_type u;
      u.sign = a[31];
      u.nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      u.inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      u.zero = (a[30:0] == 31'd0);
      if (a[30:23] == 8'd0) begin
         u.exp = 10'sd1;
         u.man = {1'b0, a[22:0]};
      end else begin
         u.exp = $signed({2'b00, a[30:23]});
         u.man = {1'b1, a[22:0]};
      end
      return u;
   endfunction

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      logic       found;
      n = 6'd48;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 6'(47 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // Round a value sign * m * 2^(e) with m in 48 bits (msb at bit 47 weighs 2^(e))
   // where e is the unbiased-plus-bias exponent of bit 47; sticky adds below.
   function automatic fp_type fp_round(input logic sign, input logic signed [11:0] e_in,
                                       input logic [47:0] m_in, input logic st_in);
      logic [5:0]  lz;
      logic [47:0] m;
      logic signed [11:0] e;
      logic [5:0]  sh;
      logic [47:0] lost;
      logic        g;
      logic        st;
      logic [24:0] q;
      fp_type      r;
      lz = lzc48(m_in);
      m = m_in << lz;
      e = e_in - 12'(lz);
      st = st_in;
      if (m_in == 48'd0) begin
         r = {sign, 31'd0};
      end else begin
         if (e < 12'sd1) begin
            sh = (e < -12'sd46) ? 6'd47 : 6'(12'sd1 - e);
            lost = m << (6'd48 - sh);
            st = st | (lost != 48'd0);
            m = m >> sh;
            e = 12'sd0;
         end
         g = m[23];
         st = st | (m[22:0] != 23'd0);
         q = {1'b0, m[47:24]} + 25'(g & (st | m[24]));
         if (q[24]) begin
            q = q >> 1;
            e = e + 12'sd1;
         end else if (e == 12'sd0 && q[23]) begin
            e = 12'sd1;
         end
         if (e >= 12'sd255) r = {sign, 8'hFF, 23'd0};
         else r = {sign, e[7:0], q[22:0]};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> design/mvm_req_if.sv
// ----------------------------------------------------------------------------
// mvm_req_if / mvm_rsp_if
// Valid-ready channels carrying requests and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface mvm_req_if;
   logic valid;
   logic ready;
   mvm_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mvm_rsp_if;
   logic valid;
   logic ready;
   mvm_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/mvm_fp_lane.sv
// ----------------------------------------------------------------------------
// mvm_fp_lane
// Pipelined multiply-then-add: sum_out = round(sum_in + round(a * b)).
// Stages: multiply, product round, align/add, normalize/round.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mvm_fp_lane (
   input  wire logic             clock,
   input  wire logic             advance,
   input  wire mvm_pkg::fp_type  a,
   input  wire mvm_pkg::fp_type  b,
   input  wire mvm_pkg::fp_type  sum_in,
   output      mvm_pkg::fp_type  sum_out
);
   mvm_pkg::unp_type ua, ub;
   logic [47:0] mprod_in, mprod_ff;
   logic signed [11:0] mexp_in, mexp_ff;
   logic        msign_ff, mnan_ff, minf_ff, mzero_ff;
   mvm_pkg::fp_type sum1_ff, sum2_ff, sum3_ff, prod_ff, prod_in;

   assign ua = mvm_pkg::fp_unpack(a);
   assign ub = mvm_pkg::fp_unpack(b);
   assign mprod_in = ua.man * ub.man;
   assign mexp_in = 12'(ua.exp) + 12'(ub.exp) - 12'sd126;

   always_ff @(posedge clock) begin
      if (advance) begin
         mprod_ff <= mprod_in;
         mexp_ff <= mexp_in;
         msign_ff <= ua.sign ^ ub.sign;
         mnan_ff <= ua.nan | ub.nan | (ua.inf & ub.zero) | (ub.inf & ua.zero);
         minf_ff <= ua.inf | ub.inf;
         mzero_ff <= ua.zero | ub.zero;
         sum1_ff <= sum_in;
      end
   end

   always_comb begin
      if (mnan_ff) prod_in = mvm_pkg::CANON_NAN;
      else if (minf_ff) prod_in = {msign_ff, 8'hFF, 23'd0};
      else if (mzero_ff) prod_in = {msign_ff, 31'd0};
      else prod_in = mvm_pkg::fp_round(msign_ff, mexp_ff, mprod_ff, 1'b0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         sum2_ff <= sum1_ff;
      end
   end

   // align and add
   mvm_pkg::unp_type ux, uy, ubig, usml;
   logic        swap;
   logic [9:0]  d;
   logic [49:0] big_m, sml_m, sml_sh;
   logic        sml_st;
   logic [50:0] add_in, add_ff;
   logic        add_sign_in, add_sign_ff, add_st_ff, add_st_in;
   logic signed [11:0] add_exp_in, add_exp_ff;
   logic        spec_in, spec_ff;
   mvm_pkg::fp_type spec_val_in, spec_val_ff;
   logic        sub;

   assign ux = mvm_pkg::fp_unpack(prod_ff);
   assign uy = mvm_pkg::fp_unpack(sum2_ff);

   always_comb begin
      swap = (uy.exp > ux.exp) || ((uy.exp == ux.exp) && (uy.man > ux.man));
      ubig = swap ? uy : ux;
      usml = swap ? ux : uy;
      d = 10'(ubig.exp - usml.exp);
      big_m = {ubig.man, 26'd0};
      sml_m = {usml.man, 26'd0};
      sml_sh = (d > 10'd49) ? 50'd0 : (sml_m >> d);
      sml_st = (d > 10'd49) ? (sml_m != 50'd0) : ((sml_sh << d) != sml_m);
      sub = ubig.sign ^ usml.sign;
      add_in = sub ? ({1'b0, big_m} - {1'b0, sml_sh} - 51'(sml_st))
                   : ({1'b0, big_m} + {1'b0, sml_sh});
      add_st_in = sml_st;
      add_sign_in = ubig.sign;
      add_exp_in = 12'(ubig.exp) + 12'sd1;
      spec_in = 1'b1;
      spec_val_in = mvm_pkg::POS_ZERO;
      if (ux.nan || uy.nan || (ux.inf && uy.inf && (ux.sign != uy.sign)))
         spec_val_in = mvm_pkg::CANON_NAN;
      else if (ux.inf) spec_val_in = prod_ff;
      else if (uy.inf) spec_val_in = sum2_ff;
      else if (ux.zero && uy.zero) spec_val_in = {ux.sign & uy.sign, 31'd0};
      else if (ux.zero) spec_val_in = sum2_ff;
      else if (uy.zero) spec_val_in = prod_ff;
      else spec_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         add_ff <= add_in;
         add_st_ff <= add_st_in;
         add_sign_ff <= add_sign_in;
         add_exp_ff <= add_exp_in;
         spec_ff <= spec_in;
         spec_val_ff <= spec_val_in;
      end
   end

   mvm_pkg::fp_type fin_in, fin_ff;
   always_comb begin
      if (spec_ff) fin_in = spec_val_ff;
      else if (add_ff == 51'd0) fin_in = mvm_pkg::POS_ZERO;
      else fin_in = mvm_pkg::fp_round(add_sign_ff, add_exp_ff,
                                      {add_ff[50:4], add_ff[3:0] != 4'd0}, add_st_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) fin_ff <= fin_in;
   end

   assign sum_out = fin_ff;
endmodule
`default_nettype wire

>>> design/matrix_vector_multiply_top.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply_top
// 4x4 single-precision matrix times vector, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req (valid/ready) with four float components and an
//   active size; results leave on rsp with four float components.
//   Matrix elements are written through the csr APB port, two per register.
//   Each row runs a chain of MAX_DIM multiply-add lanes, highest column first,
//   each lane four register stages deep. Throughput is one request per cycle
//   while rsp_ready is high or the output stage is empty.
//   Reset loads the identity matrix and empties the pipeline.
//   When the receiver stalls, the whole pipeline holds; req_ready follows
//   rsp_ready or an empty output stage, so nothing is lost or repeated.
//   Columns at or above the size see +0.0 terms, which leave the sum
//   unchanged; rows at or above the size are forced to +0.0 at the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_vector_multiply_top_defines.svh"
module matrix_vector_multiply_top #(
   parameter int unsigned MAX_DIM = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   mvm_req_if.sink                          req,
   mvm_rsp_if.source                        rsp,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [mvm_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [mvm_pkg::REG_W-1:0]   csr_pwdata,
   output      logic [mvm_pkg::REG_W-1:0]   csr_prdata,
   output      logic                        csr_pready
);
   localparam int unsigned DEPTH = 4 * MAX_DIM;

   logic [mvm_pkg::REG_W-1:0] regs_ff [mvm_pkg::NUM_REGS];
   logic [2:0] reg_idx;
   logic       wr_en;
   assign reg_idx = csr_paddr[5:3];
   assign wr_en = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2:0] == 3'd0);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2:0] == 3'd0) ? regs_ff[reg_idx] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[0] <= mvm_pkg::RESET_ROW_A;
         regs_ff[1] <= mvm_pkg::RESET_ZERO;
         regs_ff[2] <= mvm_pkg::RESET_ROW_B;
         regs_ff[3] <= mvm_pkg::RESET_ZERO;
         regs_ff[4] <= mvm_pkg::RESET_ZERO;
         regs_ff[5] <= mvm_pkg::RESET_ROW_A;
         regs_ff[6] <= mvm_pkg::RESET_ZERO;
         regs_ff[7] <= mvm_pkg::RESET_ROW_B;
      end else if (wr_en) begin
         regs_ff[reg_idx] <= csr_pwdata;
      end
   end

   mvm_pkg::fp_type mat [4][4];
   always_comb begin
      for (int i = 0; i < 16; i++)
         mat[i/4][i%4] = (i % 2 == 1) ? regs_ff[i/2][63:32] : regs_ff[i/2][31:0];
   end

   logic advance;
   logic out_valid_ff;
   mvm_pkg::rsp_type out_ff, out_in;
   assign advance = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   // front stage: clamp size, zero inactive components
   logic [2:0] n_in;
   logic [2:0] n_ff;
   logic       v0_ff;
   mvm_pkg::fp_type vec_in [4];
   mvm_pkg::fp_type vec_ff [4];
   always_comb begin
      n_in = (req.data.vec_size > 3'(MAX_DIM)) ? 3'(MAX_DIM) : req.data.vec_size;
      vec_in[0] = (n_in > 3'd0) ? req.data.comp_x : mvm_pkg::POS_ZERO;
      vec_in[1] = (n_in > 3'd1) ? req.data.comp_y : mvm_pkg::POS_ZERO;
      vec_in[2] = (n_in > 3'd2) ? req.data.comp_z : mvm_pkg::POS_ZERO;
      vec_in[3] = (n_in > 3'd3) ? req.data.comp_w : mvm_pkg::POS_ZERO;
   end

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (advance) v0_ff <= req.valid;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         n_ff <= n_in;
         vec_ff <= vec_in;
      end
   end

   // delay lines for valid, size and vector alongside the lane chain
   logic            vd_ff [DEPTH+1];
   logic [2:0]      nd_ff [DEPTH+1];
   mvm_pkg::fp_type vd_vec_ff [DEPTH+1][4];
   always_comb begin
      vd_ff[0] = v0_ff;
      nd_ff[0] = n_ff;
      vd_vec_ff[0] = vec_ff;
   end
   for (genvar s = 1; s <= DEPTH; s++) begin : g_dly
      always_ff @(posedge clock) begin
         if (reset) vd_ff[s] <= 1'b0;
         else if (advance) vd_ff[s] <= vd_ff[s-1];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            nd_ff[s] <= nd_ff[s-1];
            vd_vec_ff[s] <= vd_vec_ff[s-1];
         end
      end
   end

   // chain per row: column MAX_DIM-1 first, down to column 0
   mvm_pkg::fp_type chain [4][MAX_DIM+1];
   for (genvar r = 0; r < 4; r++) begin : g_row
      assign chain[r][0] = mvm_pkg::POS_ZERO;
      for (genvar j = 0; j < MAX_DIM; j++) begin : g_col
         mvm_pkg::fp_type a_col;
         // drop matrix elements of inactive columns
         assign a_col = (nd_ff[4*j] > 3'(MAX_DIM-1-j)) ? mat[r][MAX_DIM-1-j]
                                                        : mvm_pkg::POS_ZERO;
         mvm_fp_lane u_lane (
            .clock   (clock),
            .advance (advance),
            .a       (a_col),
            .b       (vd_vec_ff[4*j][MAX_DIM-1-j]),
            .sum_in  (chain[r][j]),
            .sum_out (chain[r][j+1])
         );
      end
   end

   logic [2:0] n_last;
   assign n_last = nd_ff[DEPTH];
   always_comb begin
      out_in.res_x = (n_last > 3'd0) ? chain[0][MAX_DIM] : mvm_pkg::POS_ZERO;
      out_in.res_y = (n_last > 3'd1) ? chain[1][MAX_DIM] : mvm_pkg::POS_ZERO;
      out_in.res_z = (n_last > 3'd2) ? chain[2][MAX_DIM] : mvm_pkg::POS_ZERO;
      out_in.res_w = (n_last > 3'd3) ? chain[3][MAX_DIM] : mvm_pkg::POS_ZERO;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (advance) out_valid_ff <= vd_ff[DEPTH];
   end
   always_ff @(posedge clock) begin
      if (advance) out_ff <= out_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_ff;

   `MVM_ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data), "stalled result changed")
   `MVM_ASSERT_IMPLY(a_ready, clock, reset, !rsp.valid, req.ready, "ready low with empty output")
   `MVM_ASSERT_NEXT(a_flow, clock, reset, advance && vd_ff[DEPTH], rsp.valid, "result lost at output")
endmodule
`default_nettype wire
